@@ hw/rtl/msm_pkg.sv @@
// msm_pkg: sizes, payload types, sequencer states and control structs
// for the minimum sum of segment maxima block
// no dependencies
package msm_pkg;

   // sequence storage and arithmetic sizes
   localparam int MAX_ITEMS   = 256;
   localparam int VALUE_BITS  = 16;
   localparam int TOTAL_BITS  = 24;
   localparam int SEG_BITS    = 9;
   localparam int COUNT_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int INDEX_BITS  = $clog2(MAX_ITEMS);
   localparam int CMP_BITS    = (COUNT_BITS > SEG_BITS) ? COUNT_BITS : SEG_BITS;

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
   localparam logic [SEG_BITS-1:0]   SEG_RESET = SEG_BITS'(1);

   // request and response payloads
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last_value;
   } req_type;

   typedef struct packed {
      logic [TOTAL_BITS-1:0] min_total;
      logic                  impossible;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_INIT_END,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_RESULT
   } msm_state_type;

   // control for the shared max/add/min unit, issued with the memory reads
   typedef struct packed {
      logic valid;     // a read was issued this cycle
      logic first;     // first element of a scan: start from empty run
      logic init_row;  // first row: running maximum only
   } msm_ctl_type;

endpackage

@@ hw/rtl/msm_ram.sv @@
// msm_ram: generic simple dual-port RAM, one write and one registered read
// no dependencies
module msm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/msm_unit.sv @@
// msm_unit: shared running-maximum, saturating add and minimum unit
// depends on msm_pkg
module msm_unit
   import msm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  msm_ctl_type           ctl,
   input  logic [VALUE_BITS-1:0] value_rd,
   input  logic [TOTAL_BITS-1:0] row_rd,
   output logic [VALUE_BITS-1:0] run_new,
   output logic [TOTAL_BITS-1:0] best
);

   msm_ctl_type             ctl_ff;
   logic [VALUE_BITS-1:0]   run_ff;
   logic [TOTAL_BITS-1:0]   best_ff;
   logic [VALUE_BITS-1:0]   run_base;
   logic [TOTAL_BITS-1:0]   best_base;
   logic [TOTAL_BITS:0]     sum;
   logic [TOTAL_BITS-1:0]   cand;
   logic [TOTAL_BITS-1:0]   best_in;

   // control is registered to line up with the registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   // running maximum, candidate and minimum
   always_comb begin
      run_base  = ctl_ff.first ? '0 : run_ff;
      best_base = ctl_ff.first ? TOTAL_MAX : best_ff;
      run_new   = (value_rd > run_base) ? value_rd : run_base;
      sum       = {1'b0, row_rd} + (TOTAL_BITS + 1)'(run_new);
      cand      = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
      best_in   = (cand < best_base) ? cand : best_base;
   end

   // accumulators, no reset needed: every scan starts with first set
   always_ff @(posedge clock) begin
      if (ctl_ff.valid) begin
         run_ff <= run_new;
         if (!ctl_ff.init_row) begin
            best_ff <= best_in;
         end
      end
   end

   assign best = best_ff;

endmodule

@@ hw/rtl/msm_seq.sv @@
// msm_seq: load counter and sequencer for the rolling dynamic program
// depends on msm_pkg
module msm_seq
   import msm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_type               req_data,
   output logic                  req_ready,
   input  logic [SEG_BITS-1:0]   seg_count,
   input  logic                  slot_free,
   output logic                  done,
   output rsp_type               result,
   output logic                  val_we,
   output logic [INDEX_BITS-1:0] val_waddr,
   output logic [INDEX_BITS-1:0] val_raddr,
   output logic                  row_we,
   output logic [INDEX_BITS-1:0] row_waddr,
   output logic [TOTAL_BITS-1:0] row_wdata,
   output logic [INDEX_BITS-1:0] row_raddr,
   output msm_ctl_type           ctl,
   input  logic [VALUE_BITS-1:0] run_new,
   input  logic [TOTAL_BITS-1:0] best
);

   msm_state_type           state_ff, state_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [SEG_BITS-1:0]     d_ff, d_in;
   logic [SEG_BITS-1:0]     s_ff, s_in;
   logic [INDEX_BITS-1:0]   i_ff, i_in;
   logic [INDEX_BITS-1:0]   k_ff, k_in;
   logic [INDEX_BITS-1:0]   k_dly_ff;
   logic                    init_wr_ff;
   logic [TOTAL_BITS-1:0]   total_ff, total_in;
   logic                    imp_ff, imp_in;

   logic                    accept;
   logic                    store;
   logic [COUNT_BITS-1:0]   n_new;
   logic                    too_few;
   logic [INDEX_BITS-1:0]   last_idx;
   logic                    k_at_floor;
   logic                    i_at_floor;
   logic                    last_row;

   // decode of the current position
   always_comb begin
      accept     = (state_ff == ST_LOAD) && req_valid;
      store      = (count_ff != COUNT_BITS'(MAX_ITEMS));
      n_new      = count_ff + COUNT_BITS'(store);
      too_few    = (seg_count == '0) || (CMP_BITS'(seg_count) > CMP_BITS'(n_new));
      last_idx   = INDEX_BITS'(count_ff - COUNT_BITS'(1));
      k_at_floor = (CMP_BITS'(k_ff) + CMP_BITS'(1)) == CMP_BITS'(s_ff);
      i_at_floor = (CMP_BITS'(i_ff) + CMP_BITS'(1)) == CMP_BITS'(s_ff);
      last_row   = (s_ff == d_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_data.last_value) begin
               state_in = too_few ? ST_RESULT : ST_INIT;
            end
         end
         ST_INIT: begin
            if (k_ff == last_idx) begin
               state_in = ST_INIT_END;
            end
         end
         ST_INIT_END: begin
            state_in = (d_ff == SEG_BITS'(1)) ? ST_RESULT : ST_SCAN;
         end
         ST_SCAN: begin
            if (k_at_floor) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = (i_at_floor && last_row) ? ST_RESULT : ST_SCAN;
         end
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // counters and result registers
   always_comb begin
      count_in = count_ff;
      d_in     = d_ff;
      s_in     = s_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      total_in = total_ff;
      imp_in   = imp_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = n_new;
               if (req_data.last_value) begin
                  d_in     = seg_count;
                  k_in     = '0;
                  total_in = '0;
                  imp_in   = too_few;
               end
            end
         end
         ST_INIT: begin
            k_in = k_ff + INDEX_BITS'(1);
         end
         ST_INIT_END: begin
            total_in = TOTAL_BITS'(run_new);
            s_in     = SEG_BITS'(2);
            i_in     = last_idx;
            k_in     = last_idx;
         end
         ST_SCAN: begin
            k_in = k_ff - INDEX_BITS'(1);
         end
         ST_WRITE: begin
            if (last_row && (i_ff == last_idx)) begin
               total_in = best;
            end
            if (i_at_floor) begin
               s_in = s_ff + SEG_BITS'(1);
               i_in = last_idx;
               k_in = last_idx;
            end else begin
               i_in = i_ff - INDEX_BITS'(1);
               k_in = i_ff - INDEX_BITS'(1);
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = (state_ff == ST_LOAD);
      done         = (state_ff == ST_RESULT);
      result       = '{min_total: total_ff, impossible: imp_ff};
      val_we       = accept && store;
      val_waddr    = count_ff[INDEX_BITS-1:0];
      val_raddr    = k_ff;
      row_raddr    = k_ff - INDEX_BITS'(1);
      ctl          = '0;
      ctl.valid    = (state_ff == ST_INIT) || (state_ff == ST_SCAN);
      ctl.init_row = (state_ff == ST_INIT);
      ctl.first    = ((state_ff == ST_INIT) && (k_ff == '0)) ||
                     ((state_ff == ST_SCAN) && (k_ff == i_ff));
      row_we       = init_wr_ff || (state_ff == ST_WRITE);
      row_waddr    = init_wr_ff ? k_dly_ff : i_ff;
      row_wdata    = init_wr_ff ? TOTAL_BITS'(run_new) : best;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         init_wr_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         init_wr_ff <= (state_ff == ST_INIT);
      end
   end

   // loop indices and result
   always_ff @(posedge clock) begin
      d_ff     <= d_in;
      s_ff     <= s_in;
      i_ff     <= i_in;
      k_ff     <= k_in;
      k_dly_ff <= k_ff;
      total_ff <= total_in;
      imp_ff   <= imp_in;
   end

endmodule

@@ hw/rtl/min_sum_of_segment_maxima.sv @@
// min_sum_of_segment_maxima: top level, csr register, memories and output register
// depends on msm_pkg, msm_ram, msm_unit, msm_seq
//
// Usage
//   req channel: one value per transaction, last_value marks the end of a
//   sequence. Values are taken one per cycle while the block is loading; past MAX_ITEMS they are dropped,
//   a dropped item with last_value still starts the computation.
//   csr channel: writes segment_count, always ready; write only while idle.
//   rsp channel: one transaction per sequence, min_total and impossible.
// Computation after the last value, n values and d segments:
//   impossible (d = 0 or d > n): straight to the result state.
//   otherwise the first row, then for each row s = 2..d and each end index
//   i = s-1..n-1 a scan of k from i down to s-1, all run
//   through the one max/add/min unit at one element per cycle, limited by
//   the single read port of the value and row memories.
// req_ready is low from the last value until the result is in the output
// register. A stalled receiver holds the result there and the block waits.
// Reset clears the sequence count, sets segment_count to 1 and empties the
// output register; memories are not cleared.
module min_sum_of_segment_maxima
   import msm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SEG_BITS-1:0] csr_data
);

   logic [SEG_BITS-1:0]   seg_count_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;
   logic                  slot_free;
   logic                  done;
   rsp_type               result;
   logic                  val_we;
   logic [INDEX_BITS-1:0] val_waddr;
   logic [INDEX_BITS-1:0] val_raddr;
   logic [VALUE_BITS-1:0] val_rdata;
   logic                  row_we;
   logic [INDEX_BITS-1:0] row_waddr;
   logic [TOTAL_BITS-1:0] row_wdata;
   logic [INDEX_BITS-1:0] row_raddr;
   logic [TOTAL_BITS-1:0] row_rdata;
   msm_ctl_type           ctl;
   logic [VALUE_BITS-1:0] run_new;
   logic [TOTAL_BITS-1:0] best;

   // segment count register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= SEG_RESET;
      end else if (csr_valid) begin
         seg_count_ff <= csr_data;
      end
   end

   // sequencer
   msm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .seg_count (seg_count_ff),
      .slot_free (slot_free),
      .done      (done),
      .result    (result),
      .val_we    (val_we),
      .val_waddr (val_waddr),
      .val_raddr (val_raddr),
      .row_we    (row_we),
      .row_waddr (row_waddr),
      .row_wdata (row_wdata),
      .row_raddr (row_raddr),
      .ctl       (ctl),
      .run_new   (run_new),
      .best      (best)
   );

   // stored sequence
   msm_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (req_data.value),
      .rd_addr (val_raddr),
      .rd_data (val_rdata)
   );

   // dynamic program row, updated in place
   msm_ram #(.WIDTH(TOTAL_BITS), .DEPTH(MAX_ITEMS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   // shared arithmetic unit
   msm_unit u_unit (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .value_rd (val_rdata),
      .row_rd   (row_rdata),
      .run_new  (run_new),
      .best     (best)
   );

   // output register
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (done && slot_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done && slot_free) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/msm_checker.sv @@
// msm_checker: port-level assertions for min_sum_of_segment_maxima, with bind
// depends on msm_pkg and the top level
module msm_checker
   import msm_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input req_type             req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input rsp_type             rsp_data,
   input logic                csr_valid,
   input logic                csr_ready,
   input logic [SEG_BITS-1:0] csr_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an impossible split reports a zero total
   a_imp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.impossible |-> rsp_data.min_total == '0)
      else $error("impossible response with non-zero total");

   // the end of a sequence closes the request channel
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_value |=> !req_ready)
      else $error("request accepted right after the last value");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the csr write side never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind min_sum_of_segment_maxima msm_checker u_msm_checker (.*);

@@ dv/tb.sv @@
// tb: self-checking testbench for min_sum_of_segment_maxima, with driver,
// receiver, monitor and a predictor of the minimum sum of segment maxima
// depends on msm_pkg and the min_sum_of_segment_maxima rtl
module tb;
   import msm_pkg::*;

   localparam int TOTAL_ITEMS = 1470;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_PCT    = 29;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [SEG_BITS-1:0] csr_data  = '0;

   // stimulus and expected results
   req_type pending_reqs [$];
   rsp_type awaited_rsps [$];

   // predictor copy of the block state
   logic [VALUE_BITS-1:0] stored_vals [MAX_ITEMS];
   int                    stored_cnt  = 0;
   logic [SEG_BITS-1:0]   seg_setting = SEG_RESET;

   // handshake bookkeeping
   logic req_fired         = 1'b0;
   int   sender_idle_pct   = IDLE_PCT;
   int   receiver_idle_pct = IDLE_PCT;
   int   hold_requests     = 0;
   int   hold_served       = 0;
   int   hold_left         = 0;

   // run statistics
   int cycle_count     = 0;
   int error_count     = 0;
   int total_queued    = 0;
   int values_accepted = 0;
   int seqs_checked    = 0;
   int impossible_seen = 0;
   int settings_used   = 0;

   min_sum_of_segment_maxima dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock, period 8
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // rolling two-row dp over the stored values, n values into d segments
   function automatic logic [TOTAL_BITS-1:0] min_split_total(int n, int d);
      int prev_row [MAX_ITEMS];
      int cur_row  [MAX_ITEMS];
      int run, best, cand, i, s, k;
      run = 0;
      for (i = 0; i < n; i++) begin
         if (int'(stored_vals[i]) > run) run = int'(stored_vals[i]);
         prev_row[i] = run;
      end
      for (s = 2; s <= d; s++) begin
         for (i = s - 1; i < n; i++) begin
            best = 32'h7fffffff;
            run  = 0;
            // last segment runs from k to i, scanned backward
            for (k = i; k >= s - 1; k--) begin
               if (int'(stored_vals[k]) > run) run = int'(stored_vals[k]);
               cand = prev_row[k-1] + run;
               if (cand < best) best = cand;
            end
            cur_row[i] = best;
         end
         for (i = s - 1; i < n; i++) prev_row[i] = cur_row[i];
      end
      if (prev_row[n-1] > int'(TOTAL_MAX)) return TOTAL_MAX;
      return TOTAL_BITS'(prev_row[n-1]);
   endfunction

   // request driver: new transaction only once the previous one is taken
   always @(negedge clock) begin : req_driver
      logic    nxt_valid;
      req_type nxt_data;
      nxt_valid = req_valid;
      nxt_data  = req_data;
      if (!reset && (!req_valid || req_fired)) begin
         nxt_valid = 1'b0;
         if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            nxt_data  = pending_reqs.pop_front();
            nxt_valid = 1'b1;
         end
      end
      req_valid <= nxt_valid;
      req_data  <= nxt_data;
   end

   // response receiver with random stalls and long hold-offs on request
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left   = HOLD_CYCLES;
         hold_served = hold_requests;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // monitor: predicts on accepted requests, checks accepted responses
   always @(posedge clock) begin : monitor
      rsp_type want;
      req_fired = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) seg_setting = csr_data;
         if (req_valid && req_ready) begin
            req_fired = 1'b1;
            values_accepted++;
            // values past the store size are dropped
            if (stored_cnt < MAX_ITEMS) begin
               stored_vals[stored_cnt] = req_data.value;
               stored_cnt++;
            end
            if (req_data.last_value) begin
               if (seg_setting == 0 || int'(seg_setting) > stored_cnt) begin
                  want.min_total  = '0;
                  want.impossible = 1'b1;
               end else begin
                  want.min_total  = min_split_total(stored_cnt, int'(seg_setting));
                  want.impossible = 1'b0;
               end
               awaited_rsps.push_back(want);
               stored_cnt = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsps.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result min_total=%0d impossible=%0b",
                        $time, rsp_data.min_total, rsp_data.impossible);
            end else begin
               want = awaited_rsps.pop_front();
               seqs_checked++;
               if (want.impossible) impossible_seen++;
               if (rsp_data.min_total !== want.min_total) begin
                  error_count++;
                  $display("%0t: min_total expected %0d actual %0d",
                           $time, want.min_total, rsp_data.min_total);
               end
               if (rsp_data.impossible !== want.impossible) begin
                  error_count++;
                  $display("%0t: impossible expected %0b actual %0b",
                           $time, want.impossible, rsp_data.impossible);
               end
            end
         end
      end
   end

   task automatic queue_item(logic [VALUE_BITS-1:0] v, logic last);
      req_type item;
      item.value      = v;
      item.last_value = last;
      pending_reqs.push_back(item);
      total_queued++;
   endtask

   // random value with extremes and narrow ranges to produce ties
   function automatic logic [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2, 3: begin
            return VALUE_BITS'($urandom_range(7));
         end
         default: begin
            return VALUE_BITS'($urandom);
         end
      endcase
   endfunction

   task automatic queue_sequence(int len);
      int j;
      for (j = 0; j < len; j++) queue_item(pick_value(), j == len - 1);
   endtask

   // wait until every transaction is taken and every result has come back
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // segment count write, only while the block is idle
   task automatic set_segments(int d);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= SEG_BITS'(d);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // stimulus sequence
   initial begin : stimulus
      int phase, d, seqs, len, j, r;
      int extremes [3];
      extremes = '{0, 256, 511};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset setting of one segment
      queue_item('1, 1'b1);
      queue_item('0, 1'b1);
      queue_item(16'd3, 1'b0);
      queue_item('0, 1'b0);
      queue_item('1, 1'b0);
      queue_item(16'd2, 1'b1);
      // directed: three segments, too few values then full sequences
      set_segments(3);
      queue_item(16'd1, 1'b0);
      queue_item(16'd2, 1'b1);
      queue_item('1, 1'b0);
      queue_item('1, 1'b0);
      queue_item('1, 1'b1);
      queue_item(16'd5, 1'b0);
      queue_item(16'd1, 1'b0);
      queue_item(16'd4, 1'b0);
      queue_item(16'd2, 1'b0);
      queue_item(16'd8, 1'b1);
      // directed: zero segments and out-of-range counts
      set_segments(0);
      queue_item(16'd9, 1'b1);
      set_segments(511);
      queue_item(16'd4, 1'b0);
      queue_item(16'd4, 1'b1);
      set_segments(256);
      queue_item(16'd1, 1'b1);
      set_segments(2);
      queue_item(16'haaaa, 1'b0);
      queue_item(16'h5555, 1'b1);

      // random phases, one segment count each
      phase = 0;
      while (total_queued < TOTAL_ITEMS) begin
         if (phase == 4) begin
            // long sequences: store exactly full, then overfull with a dropped last
            set_segments(1);
            queue_sequence(MAX_ITEMS);
            set_segments(3);
            queue_sequence(MAX_ITEMS);
            set_segments(2);
            queue_sequence(MAX_ITEMS + 44);
            set_segments(8);
            queue_sequence(40);
            queue_sequence(33);
         end else begin
            if (phase % 6 == 3) d = extremes[$urandom_range(2)];
            else d = $urandom_range(1, 8);
            set_segments(d);
            // a stretch with no idling, otherwise random idling on both sides
            sender_idle_pct   = (phase == 1) ? 0 : IDLE_PCT;
            receiver_idle_pct = (phase == 1) ? 0 : IDLE_PCT;
            // long receiver hold-off while the sender keeps offering
            if (phase == 2 || phase == 9) hold_requests++;
            seqs = $urandom_range(8, 16);
            for (j = 0; j < seqs; j++) begin
               r = $urandom_range(99);
               if (d == 0 || d > 64) len = $urandom_range(1, 12);
               else if (r < 15 && d > 1) len = $urandom_range(1, d - 1);
               else len = $urandom_range(d, d + 6);
               queue_sequence(len);
            end
         end
         phase++;
      end

      wait_idle();
      repeat (16) @(posedge clock);
      $display("checked %0d sequences (%0d impossible) from %0d values",
               seqs_checked, impossible_seen, values_accepted);
      $display("over %0d segment count settings in %0d cycles",
               settings_used, cycle_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/msm_pkg.sv
hw/rtl/msm_ram.sv
hw/rtl/msm_unit.sv
hw/rtl/msm_seq.sv
hw/rtl/min_sum_of_segment_maxima.sv
hw/rtl/msm_checker.sv
dv/tb.sv
